FILE: rtl/rssd_pkg.sv
// Shared constants, codes and types of the serial LED strip driver.
package rssd_pkg;

	localparam int MAX_PIXELS_DEF = 256;

	localparam int PIXEL_W = 24;
	localparam int PTR_W   = 8;
	localparam int BIT_W   = 5;
	localparam int TICK_W  = 14;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [BIT_W-1:0] LAST_BIT = 5'd23;

	// Waveform phases.
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_HIGH  = 2'd1;
	localparam logic [1:0] PH_LOW   = 2'd2;
	localparam logic [1:0] PH_LATCH = 2'd3;

	// Request opcodes.
	localparam logic OP_TICK = 1'b0;
	localparam logic OP_SET  = 1'b1;

	// Status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_INDEX = 2'd1;
	localparam logic [1:0] ST_BUSY  = 2'd2;

	// Register indexes (byte address / 4).
	localparam logic [2:0] REG_STRIP_LENGTH = 3'd0;
	localparam logic [2:0] REG_ZERO_HIGH    = 3'd1;
	localparam logic [2:0] REG_ZERO_LOW     = 3'd2;
	localparam logic [2:0] REG_ONE_HIGH     = 3'd3;
	localparam logic [2:0] REG_ONE_LOW      = 3'd4;
	localparam logic [2:0] REG_LATCH        = 3'd5;

	// Register reset values.
	localparam logic [7:0]        RST_STRIP_LENGTH = 8'd0;
	localparam logic [7:0]        RST_ZERO_HIGH    = 8'd12;
	localparam logic [7:0]        RST_ZERO_LOW     = 8'd36;
	localparam logic [7:0]        RST_ONE_HIGH     = 8'd36;
	localparam logic [7:0]        RST_ONE_LOW      = 8'd36;
	localparam logic [TICK_W-1:0] RST_LATCH        = 14'd12000;

	typedef struct packed {
		logic       line_level;
		logic       busy_res;
		logic [1:0] status;
		logic       frame_done;
	} res_t;

endpackage

FILE: rtl/rssd_store.sv
// Pixel store: synchronous memory with one registered read port and per-entry valid bits.
module rssd_store #(
	parameter int DEPTH = rssd_pkg::MAX_PIXELS_DEF,
	parameter int AW    = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [AW-1:0]                wr_addr,
	input  logic [rssd_pkg::PIXEL_W-1:0] wr_data,
	input  logic [AW-1:0]                rd_addr,
	output logic [rssd_pkg::PIXEL_W-1:0] rd_data
);
	import rssd_pkg::*;

	logic [PIXEL_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]   valid_q;
	logic [PIXEL_W-1:0] rd_word_q;
	logic               rd_valid_q;
	logic               rd_hit;
	logic [AW-1:0]      rd_idx;

	// Addresses past the depth read as an unwritten entry.
	assign rd_hit = ({1'b0, rd_addr} < (AW+1)'(DEPTH));
	assign rd_idx = rd_hit ? rd_addr : '0;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_word_q <= mem[rd_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rd_valid_q <= rd_hit && valid_q[rd_idx];
		end
	end

	assign rd_data = rd_valid_q ? rd_word_q : '0;

endmodule

FILE: rtl/rgb_strip_serial_driver_top.sv
// Top level of the serial LED strip driver: registers, waveform sequencer and result queue.
//
// Channel   Handshake              Payload
// request   req_valid / req_ready  opcode, pixel_index, red, green, blue
// result    res_valid / res_ready  line_level, busy_res, status, frame_done
// config    APB write/read         paddr, pwdata, prdata
//
// One request is taken every cycle while req_ready is high; its result is registered into the result queue.
// A two-entry result queue keeps requests flowing while results wait; req_ready drops
// only when both entries are full. The next pixel is prefetched from the store during
// the current pixel, so the registered memory read never stalls the waveform.
// Reset clears the valid bits of the store at once; there is no clearing pass.
module rgb_strip_serial_driver_top #(
	parameter int MAX_PIXELS = rssd_pkg::MAX_PIXELS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_ready,
	input  logic                         opcode,
	input  logic [7:0]                   pixel_index,
	input  logic [7:0]                   red,
	input  logic [7:0]                   green,
	input  logic [7:0]                   blue,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic                         line_level,
	output logic                         busy_res,
	output logic [1:0]                   status,
	output logic                         frame_done,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rssd_pkg::PADDR_W-1:0] paddr,
	input  logic [rssd_pkg::PDATA_W-1:0] pwdata,
	output logic [rssd_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import rssd_pkg::*;

	localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam logic [PTR_W:0] MAX_LEN = (PTR_W+1)'(MAX_PIXELS);

	// Configuration registers.
	logic [7:0]        strip_length_q;
	logic [7:0]        zero_high_q;
	logic [7:0]        zero_low_q;
	logic [7:0]        one_high_q;
	logic [7:0]        one_low_q;
	logic [TICK_W-1:0] latch_q;
	logic              cfg_wr;
	logic [2:0]        reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = paddr[PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strip_length_q <= RST_STRIP_LENGTH;
			zero_high_q    <= RST_ZERO_HIGH;
			zero_low_q     <= RST_ZERO_LOW;
			one_high_q     <= RST_ONE_HIGH;
			one_low_q      <= RST_ONE_LOW;
			latch_q        <= RST_LATCH;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_STRIP_LENGTH: strip_length_q <= pwdata[7:0];
				REG_ZERO_HIGH:    zero_high_q    <= pwdata[7:0];
				REG_ZERO_LOW:     zero_low_q     <= pwdata[7:0];
				REG_ONE_HIGH:     one_high_q     <= pwdata[7:0];
				REG_ONE_LOW:      one_low_q      <= pwdata[7:0];
				REG_LATCH:        latch_q        <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_STRIP_LENGTH: prdata = {24'd0, strip_length_q};
			REG_ZERO_HIGH:    prdata = {24'd0, zero_high_q};
			REG_ZERO_LOW:     prdata = {24'd0, zero_low_q};
			REG_ONE_HIGH:     prdata = {24'd0, one_high_q};
			REG_ONE_LOW:      prdata = {24'd0, one_low_q};
			REG_LATCH:        prdata = {{(PDATA_W-TICK_W){1'b0}}, latch_q};
			default:          prdata = '0;
		endcase
	end

	// Waveform state.
	logic [1:0]         phase_q, phase_d;
	logic [PTR_W-1:0]   ptr_q, ptr_d;
	logic [BIT_W-1:0]   bit_q, bit_d;
	logic [TICK_W-1:0]  tick_q, tick_d;
	logic [PIXEL_W-1:0] shift_q, shift_d;

	logic               push, pop;
	logic [PTR_W:0]     live_len;
	logic [PTR_W:0]     ptr_inc;
	logic [TICK_W:0]    tick_inc;
	logic [7:0]         hi_dur, lo_dur;
	logic               end_hi, end_lo, end_latch;
	logic               wr_en;
	logic [PIXEL_W-1:0] wr_data;
	logic [AW-1:0]      rd_addr;
	logic [PIXEL_W-1:0] rd_data;
	res_t               res_new;

	assign live_len = ({1'b0, strip_length_q} < MAX_LEN) ? {1'b0, strip_length_q} : MAX_LEN;
	assign ptr_inc  = {1'b0, ptr_q} + 1'b1;
	assign tick_inc = {1'b0, tick_q} + 1'b1;
	assign hi_dur   = shift_q[PIXEL_W-1] ? one_high_q : zero_high_q;
	assign lo_dur   = shift_q[PIXEL_W-1] ? one_low_q : zero_low_q;
	// A duration of zero ends on the first tick, like a duration of one.
	assign end_hi    = tick_inc >= {{(TICK_W-7){1'b0}}, hi_dur};
	assign end_lo    = tick_inc >= {{(TICK_W-7){1'b0}}, lo_dur};
	assign end_latch = tick_inc >= {1'b0, latch_q};
	assign wr_data   = {green, red, blue};

	// While bits go out, the read port fetches the following pixel; otherwise it
	// holds pixel zero ready for the next frame start.
	assign rd_addr = (phase_q == PH_HIGH || phase_q == PH_LOW) ? ptr_inc[AW-1:0] : '0;

	always_comb begin
		phase_d = phase_q;
		ptr_d   = ptr_q;
		bit_d   = bit_q;
		tick_d  = tick_q;
		shift_d = shift_q;
		wr_en   = 1'b0;
		res_new = '{line_level: 1'b0, busy_res: 1'b0, status: ST_OK, frame_done: 1'b0};
		if (opcode == OP_SET) begin
			if (phase_q != PH_IDLE) begin
				res_new.status = ST_BUSY;
			end else if ({1'b0, pixel_index} >= live_len) begin
				res_new.status = ST_INDEX;
			end else begin
				wr_en   = push;
				ptr_d   = '0;
				bit_d   = '0;
				tick_d  = '0;
				phase_d = PH_HIGH;
				// Forward the word being written when it is pixel zero itself.
				shift_d = (pixel_index == '0) ? wr_data : rd_data;
			end
		end else begin
			unique case (phase_q)
				PH_HIGH: begin
					res_new.line_level = 1'b1;
					if (end_hi) begin
						tick_d  = '0;
						phase_d = PH_LOW;
					end else begin
						tick_d = tick_inc[TICK_W-1:0];
					end
				end
				PH_LOW: begin
					if (end_lo) begin
						tick_d = '0;
						if (bit_q < LAST_BIT) begin
							bit_d   = bit_q + 1'b1;
							shift_d = {shift_q[PIXEL_W-2:0], 1'b0};
							phase_d = PH_HIGH;
						end else if (ptr_inc < live_len) begin
							ptr_d   = ptr_inc[PTR_W-1:0];
							bit_d   = '0;
							shift_d = rd_data;
							phase_d = PH_HIGH;
						end else begin
							bit_d   = '0;
							phase_d = PH_LATCH;
						end
					end else begin
						tick_d = tick_inc[TICK_W-1:0];
					end
				end
				PH_LATCH: begin
					if (end_latch) begin
						tick_d             = '0;
						ptr_d              = '0;
						phase_d            = PH_IDLE;
						res_new.frame_done = 1'b1;
					end else begin
						tick_d = tick_inc[TICK_W-1:0];
					end
				end
				default: ;
			endcase
		end
		res_new.busy_res = (phase_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ptr_q   <= '0;
			bit_q   <= '0;
			tick_q  <= '0;
			shift_q <= '0;
		end else if (push) begin
			phase_q <= phase_d;
			ptr_q   <= ptr_d;
			bit_q   <= bit_d;
			tick_q  <= tick_d;
			shift_q <= shift_d;
		end
	end

	rssd_store #(
		.DEPTH (MAX_PIXELS),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (pixel_index[AW-1:0]),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Two-entry result queue: head register plus one skid entry.
	res_t       head_q, skid_q;
	logic [1:0] count_q;

	assign req_ready = (count_q != 2'd2);
	assign res_valid = (count_q != 2'd0);
	assign push      = req_valid && req_ready;
	assign pop       = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (count_q == 2'd2) begin
				head_q <= skid_q;
			end else if (push) begin
				head_q <= res_new;
			end
		end else if (push) begin
			if (count_q == 2'd0) begin
				head_q <= res_new;
			end else begin
				skid_q <= res_new;
			end
		end
	end

	assign line_level = head_q.line_level;
	assign busy_res   = head_q.busy_res;
	assign status     = head_q.status;
	assign frame_done = head_q.frame_done;

endmodule
